>>> sv/lde_pkg.sv
`default_nettype none

package lde_pkg;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_HIDE_FIRST = 3'd2;
    localparam logic [2:0] CMD_HIDE_ALL   = 3'd3;
    localparam logic [2:0] CMD_CONTAINS   = 3'd4;
    localparam logic [2:0] CMD_READ_AT    = 3'd5;
    localparam logic [2:0] CMD_CLEAR      = 3'd6;

    // kind of walk over the stored entries
    typedef enum logic [1:0] {
        PASS_SCAN,
        PASS_SHIFT,
        PASS_COMPACT
    } t_pass;

    typedef struct packed {
        logic start;
        logic run;
        logic append_wr;
        logic push_front_wr;
        logic compact_end;
        logic clear_all;
        logic set_full;
        logic out_load;
    } t_dp_act;

    typedef struct packed {
        t_dp_act    act;
        logic [2:0] cmd;
        t_pass      mode;
    } t_dp_ctl;

    typedef struct packed {
        logic full;
        logic compact_due;
        logic pass_done;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> sv/lde_dpath.sv
`default_nettype none

module lde_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic signed [31:0]  i_value,
    input  logic [7:0]          i_position,
    input  lde_pkg::t_dp_ctl    i_ctl,
    output lde_pkg::t_dp_sts    o_sts,
    output logic                o_ok,
    output logic [4:0]          o_removed_count,
    output logic signed [31:0]  o_read_value,
    output logic [4:0]          o_visible_count,
    output logic [4:0]          o_hid_count,
    output logic                o_full_error
);
    import lde_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    function automatic logic [4:0] sat5(input logic [CW-1:0] x);
        sat5 = (x > CW'(31)) ? 5'd31 : 5'(x);
    endfunction

    // entry store: hidden mark on top of the value
    logic [32:0]    r_mem [DEPTH];
    logic [32:0]    r_rdata;

    logic [CW-1:0]  r_used;
    logic [CW-1:0]  r_vis;
    logic [CW-1:0]  r_hid;
    logic [CW-1:0]  r_removed;
    logic [CW-1:0]  r_iss;
    logic [CW-1:0]  r_left;
    logic [CW-1:0]  r_seen;
    logic [CW-1:0]  r_w;
    logic [AW-1:0]  r_pidx;
    logic           r_pvalid;
    logic [31:0]    r_value;
    logic [7:0]     r_pos;
    logic           r_found;
    logic           r_full;
    logic [31:0]    r_rd;

    logic           r_out_ok;
    logic [4:0]     r_out_removed;
    logic [31:0]    r_out_rd;
    logic [4:0]     r_out_vis;
    logic [4:0]     r_out_hid;
    logic           r_out_full;

    logic           w_hid_bit;
    logic [31:0]    w_val;
    logic           w_stage;
    logic           w_match;
    logic           w_scan;
    logic           w_do_hide;
    logic           w_do_find;
    logic           w_read_vis;
    logic           w_pos_hit;
    logic           w_do_shift;
    logic           w_do_keep;
    logic           w_issue;
    logic           w_push;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [32:0]    w_wdata;

    always_comb begin
        w_hid_bit  = r_rdata[32];
        w_val      = r_rdata[31:0];
        w_stage    = i_ctl.act.run && r_pvalid;
        w_scan     = w_stage && (i_ctl.mode == PASS_SCAN);
        w_match    = !w_hid_bit && (w_val == r_value);
        w_do_hide  = w_scan && w_match
                     && ((i_ctl.cmd == CMD_HIDE_ALL)
                         || ((i_ctl.cmd == CMD_HIDE_FIRST) && !r_found));
        w_do_find  = w_scan && w_match && (i_ctl.cmd == CMD_CONTAINS);
        w_read_vis = w_scan && !w_hid_bit && !r_found && (i_ctl.cmd == CMD_READ_AT);
        w_pos_hit  = (PW'(r_seen) == PW'(r_pos));
        w_do_shift = w_stage && (i_ctl.mode == PASS_SHIFT);
        w_do_keep  = w_stage && (i_ctl.mode == PASS_COMPACT) && !w_hid_bit;
        w_issue    = i_ctl.act.run && (r_left != '0);
        w_push     = i_ctl.act.append_wr || i_ctl.act.push_front_wr;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        if (i_ctl.act.append_wr) begin
            w_we    = 1'b1;
            w_waddr = r_used[AW-1:0];
            w_wdata = {1'b0, r_value};
        end else if (i_ctl.act.push_front_wr) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {1'b0, r_value};
        end else if (w_do_shift) begin
            w_we    = 1'b1;
            w_waddr = r_pidx + AW'(1);
            w_wdata = r_rdata;
        end else if (w_do_hide) begin
            w_we    = 1'b1;
            w_waddr = r_pidx;
            w_wdata = {1'b1, w_val};
        end else if (w_do_keep) begin
            w_we    = 1'b1;
            w_waddr = r_w[AW-1:0];
            w_wdata = {1'b0, w_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rdata <= r_mem[r_iss[AW-1:0]];
        end
    end

    // counts and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_vis    <= '0;
            r_hid    <= '0;
            r_left   <= '0;
            r_pvalid <= 1'b0;
        end else begin
            if (i_ctl.act.start) begin
                r_left   <= r_used;
                r_pvalid <= 1'b0;
            end else if (i_ctl.act.run) begin
                r_pvalid <= w_issue;
                if (w_issue) begin
                    r_left <= r_left - CW'(1);
                end
            end
            if (i_ctl.act.clear_all) begin
                r_used <= '0;
                r_vis  <= '0;
                r_hid  <= '0;
            end else if (w_push) begin
                r_used <= r_used + CW'(1);
                r_vis  <= r_vis + CW'(1);
            end else if (w_do_hide) begin
                r_vis <= r_vis - CW'(1);
                r_hid <= r_hid + CW'(1);
            end else if (i_ctl.act.compact_end) begin
                r_used <= r_w;
                r_hid  <= '0;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_value   <= $unsigned(i_value);
            r_pos     <= i_position;
            r_found   <= 1'b0;
            r_full    <= 1'b0;
            r_removed <= '0;
            r_rd      <= '0;
        end else begin
            if (w_push || w_do_hide || w_do_find || (w_read_vis && w_pos_hit)) begin
                r_found <= 1'b1;
            end
            if (w_do_hide) begin
                r_removed <= r_removed + CW'(1);
            end
            if (w_read_vis && w_pos_hit) begin
                r_rd <= w_val;
            end
            if (i_ctl.act.set_full) begin
                r_full <= 1'b1;
            end
        end
        if (i_ctl.act.start) begin
            r_iss  <= (i_ctl.mode == PASS_SHIFT) ? r_used - CW'(1) : '0;
            r_seen <= '0;
            r_w    <= '0;
        end else begin
            if (w_issue) begin
                r_iss  <= (i_ctl.mode == PASS_SHIFT) ? r_iss - CW'(1) : r_iss + CW'(1);
                r_pidx <= r_iss[AW-1:0];
            end
            if (w_read_vis && !w_pos_hit) begin
                r_seen <= r_seen + CW'(1);
            end
            if (w_do_keep) begin
                r_w <= r_w + CW'(1);
            end
        end
        if (i_ctl.act.out_load) begin
            r_out_ok      <= r_found;
            r_out_removed <= sat5(r_removed);
            r_out_rd      <= r_rd;
            r_out_vis     <= sat5(r_vis);
            r_out_hid     <= sat5(r_hid);
            r_out_full    <= r_full;
        end
    end

    always_comb begin
        o_sts.full        = (r_used == CW'(DEPTH));
        o_sts.compact_due = (r_hid == r_vis) && (r_hid != '0);
        o_sts.pass_done   = (r_left == '0) && !r_pvalid;
    end

    assign o_ok            = r_out_ok;
    assign o_removed_count = r_out_removed;
    assign o_read_value    = $signed(r_out_rd);
    assign o_visible_count = r_out_vis;
    assign o_hid_count     = r_out_hid;
    assign o_full_error    = r_out_full;

`ifndef NO_ASSERTIONS
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_vis) + (CW+1)'(r_hid) == (CW+1)'(r_used))
        else $error("visible plus hidden differs from held entries");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(DEPTH))
        else $error("held entries exceed store depth");

    a_compact_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.act.compact_end |=> (r_hid == '0) && (r_used == r_vis))
        else $error("compaction left hidden entries");
`endif

endmodule

`default_nettype wire

>>> sv/lde_ctrl.sv
`default_nettype none

module lde_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_cmd,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  lde_pkg::t_dp_sts i_sts,
    output lde_pkg::t_dp_ctl o_ctl
);
    import lde_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_PASS,
        S_APPLY,
        S_CHECK,
        S_WRAP,
        S_EMIT
    } t_state;

    t_state     r_state;
    logic       r_ready;
    logic       r_valid;
    logic [2:0] r_cmd;
    t_pass      r_mode;
    t_dp_act    r_act;

    always_ff @(posedge i_clk) begin
        t_dp_act n_act;
        n_act = '0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
            r_cmd   <= CMD_CLEAR;
            r_mode  <= PASS_SCAN;
            r_act   <= '0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && r_ready) begin
                        r_cmd   <= i_cmd;
                        r_ready <= 1'b0;
                        r_state <= S_DECODE;
                    end else begin
                        r_ready <= 1'b1;
                    end
                end
                S_DECODE: begin
                    unique case (r_cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            if (i_sts.full) begin
                                n_act.set_full = 1'b1;
                                r_state        <= S_APPLY;
                            end else if (r_cmd == CMD_PUSH_BACK) begin
                                n_act.append_wr = 1'b1;
                                r_state         <= S_APPLY;
                            end else begin
                                n_act.start = 1'b1;
                                r_mode      <= PASS_SHIFT;
                                r_state     <= S_START;
                            end
                        end
                        CMD_HIDE_FIRST, CMD_HIDE_ALL, CMD_CONTAINS, CMD_READ_AT: begin
                            n_act.start = 1'b1;
                            r_mode      <= PASS_SCAN;
                            r_state     <= S_START;
                        end
                        CMD_CLEAR: begin
                            n_act.clear_all = 1'b1;
                            r_state         <= S_APPLY;
                        end
                        default: begin
                            r_state <= S_APPLY;
                        end
                    endcase
                end
                S_START: begin
                    n_act.run = 1'b1;
                    r_state   <= S_PASS;
                end
                S_PASS: begin
                    if (!i_sts.pass_done) begin
                        n_act.run = 1'b1;
                    end else if (r_mode == PASS_SHIFT) begin
                        n_act.push_front_wr = 1'b1;
                        r_state             <= S_APPLY;
                    end else if (r_mode == PASS_COMPACT) begin
                        n_act.compact_end = 1'b1;
                        r_state           <= S_APPLY;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_APPLY: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_sts.compact_due) begin
                        n_act.start = 1'b1;
                        r_mode      <= PASS_COMPACT;
                        r_state     <= S_START;
                    end else begin
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // wait until the result register is free
                    if (!r_valid || i_ready) begin
                        n_act.out_load = 1'b1;
                        r_state        <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_ready <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            r_act <= n_act;
        end
    end

    assign o_ready = r_ready;
    assign o_valid = r_valid;

    always_comb begin
        o_ctl.act  = r_act;
        o_ctl.cmd  = r_cmd;
        o_ctl.mode = r_mode;
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE))
        else $error("ready raised outside idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act.out_load |-> !r_valid)
        else $error("result register overwritten while full");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> r_valid && (r_state == S_IDLE))
        else $error("result not presented after load");
`endif

endmodule

`default_nettype wire

>>> sv/lazy_delete_list_engine.sv
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values with lazy deletion. Each input item is
// one command (push front/back, hide first/all matches, contains, read the i-th visible
// value, clear) and yields exactly one result item carrying the status flags and the
// visible and hidden counts (saturated at 31). Entries live in a memory with one write and
// one registered read port, so every walk over the list advances one entry per cycle.
// Push back, clear and refused pushes need no walk; hide, contains and read at walk the
// held entries once; push front first walks them to shift each one up by one place. When a
// push or hide leaves the hidden count equal to a nonzero visible count, a compaction walk
// over the entries then held follows.
// A new item is accepted once the previous result is loaded, even if it is not yet taken.
module lazy_delete_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_cmd,
    input  logic signed [31:0]  i_value,
    input  logic [7:0]          i_position,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_ok,
    output logic [4:0]          o_removed_count,
    output logic signed [31:0]  o_read_value,
    output logic [4:0]          o_visible_count,
    output logic [4:0]          o_hid_count,
    output logic                o_full_error
);
    import lde_pkg::*;

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;
    logic    w_take;

    assign w_take = i_valid && o_ready;

    lde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    lde_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_value         (i_value),
        .i_position      (i_position),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .o_ok            (o_ok),
        .o_removed_count (o_removed_count),
        .o_read_value    (o_read_value),
        .o_visible_count (o_visible_count),
        .o_hid_count     (o_hid_count),
        .o_full_error    (o_full_error)
    );

endmodule

`default_nettype wire
